// ----- design/bld_pkg.sv -----
package bld_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_ADDR_W      = 5;
    localparam int RES_CNT_W       = 16;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_W      = 2;
    localparam int FIFO_CNT_W      = 3;

    localparam logic [15:0] POLL_PERIOD_RST     = 16'd200;
    localparam logic [15:0] LONG_POLLS_RST      = 16'd10;
    localparam logic        CLEAR_EACH_POLL_RST = 1'b1;
    localparam logic        ACTIVE_LOW_RST      = 1'b0;
    localparam logic        QUIET_MODE_RST      = 1'b0;

    typedef enum logic [1:0] {
        OP_INTERRUPT = 2'd0,
        OP_TICK      = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_RESERVED  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        EV_PRESSED  = 2'd0,
        EV_SHORT    = 2'd1,
        EV_RELEASED = 2'd2,
        EV_LONG     = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        REG_POLL_PERIOD     = 3'd0,
        REG_LONG_POLLS      = 3'd1,
        REG_CLEAR_EACH_POLL = 3'd2,
        REG_ACTIVE_LOW      = 3'd3,
        REG_QUIET_MODE      = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [15:0] poll_period_ms;
        logic [15:0] long_press_polls;
        logic        clear_each_poll;
        logic        active_low;
        logic        quiet_mode;
    } cfg_t;

    typedef struct packed {
        event_t                 event_res;
        logic [RES_CNT_W-1:0]   long_press_count;
        logic                   indicated;
        logic                   last;
    } result_t;

    // Results produced by one item: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ----- design/bld_cfg_regs.sv -----
module bld_cfg_regs
    import bld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_period_ms   <= POLL_PERIOD_RST;
            cfg_reg.long_press_polls <= LONG_POLLS_RST;
            cfg_reg.clear_each_poll  <= CLEAR_EACH_POLL_RST;
            cfg_reg.active_low       <= ACTIVE_LOW_RST;
            cfg_reg.quiet_mode       <= QUIET_MODE_RST;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_POLL_PERIOD:     cfg_reg.poll_period_ms   <= pwdata[15:0];
                REG_LONG_POLLS:      cfg_reg.long_press_polls <= pwdata[15:0];
                REG_CLEAR_EACH_POLL: cfg_reg.clear_each_poll  <= pwdata[0];
                REG_ACTIVE_LOW:      cfg_reg.active_low       <= pwdata[0];
                REG_QUIET_MODE:      cfg_reg.quiet_mode       <= pwdata[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_POLL_PERIOD:     prdata = {16'd0, cfg_reg.poll_period_ms};
            REG_LONG_POLLS:      prdata = {16'd0, cfg_reg.long_press_polls};
            REG_CLEAR_EACH_POLL: prdata = {31'd0, cfg_reg.clear_each_poll};
            REG_ACTIVE_LOW:      prdata = {31'd0, cfg_reg.active_low};
            REG_QUIET_MODE:      prdata = {31'd0, cfg_reg.quiet_mode};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

// ----- design/bld_step.sv -----
module bld_step
    import bld_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  opcode_t opcode,
    input  logic    int_status,
    input  logic    pin_level,
    input  logic    clear_value,
    input  cfg_t    cfg,
    output push_t   push
);

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic                   polling_reg, polling_next;
    logic                   int_en_reg, int_en_next;
    logic [COUNT_WIDTH-1:0] ms_count_reg, ms_count_next;
    logic [COUNT_WIDTH-1:0] poll_count_reg, poll_count_next;
    logic [COUNT_WIDTH-1:0] steps_reg, steps_next;
    logic                   ind_reg, ind_next;

    logic [COUNT_WIDTH-1:0] ms_inc;
    logic [COUNT_WIDTH-1:0] poll_inc;
    logic [COUNT_WIDTH-1:0] steps_inc;
    logic                   pressed;
    logic [1:0]             n;
    event_t                 ev0, ev1;
    logic [RES_CNT_W-1:0]   cnt0;

    assign ms_inc    = (ms_count_reg == '1) ? ms_count_reg : ms_count_reg + 1'b1;
    assign poll_inc  = (poll_count_reg == '1) ? poll_count_reg : poll_count_reg + 1'b1;
    assign steps_inc = (steps_reg == '1) ? steps_reg : steps_reg + 1'b1;
    assign pressed   = pin_level ^ cfg.active_low;

    always_comb
    begin
        polling_next    = polling_reg;
        int_en_next     = int_en_reg;
        ms_count_next   = ms_count_reg;
        poll_count_next = poll_count_reg;
        steps_next      = steps_reg;
        ind_next        = ind_reg;
        n               = 2'd0;
        ev0             = EV_PRESSED;
        ev1             = EV_RELEASED;
        cnt0            = '0;
        if (item_valid)
        begin
            unique case (opcode)
                OP_INTERRUPT:
                begin
                    if (int_en_reg && int_status)
                    begin
                        int_en_next     = 1'b0;
                        n               = 2'd1;
                        ev0             = EV_PRESSED;
                        poll_count_next = '0;
                        steps_next      = '0;
                        polling_next    = 1'b1;
                        ms_count_next   = '0;
                    end
                end
                OP_TICK:
                begin
                    if (polling_reg)
                    begin
                        ms_count_next = ms_inc;
                        if (CMP_W'(ms_inc) >= CMP_W'(cfg.poll_period_ms))
                        begin
                            ms_count_next = '0;
                            polling_next  = 1'b0;
                            if (!ind_reg)
                            begin
                                if (!pressed)
                                begin
                                    // A short press only when no long step was seen.
                                    if (!cfg.quiet_mode)
                                    begin
                                        ind_next = 1'b1;
                                    end
                                    if (steps_reg == '0 && !cfg.quiet_mode)
                                    begin
                                        n   = 2'd2;
                                        ev0 = EV_SHORT;
                                    end
                                    else
                                    begin
                                        n   = 2'd1;
                                        ev0 = EV_RELEASED;
                                    end
                                    int_en_next = 1'b1;
                                end
                                else
                                begin
                                    poll_count_next = poll_inc;
                                    if (CMP_W'(poll_inc) == CMP_W'(cfg.long_press_polls)
                                        && !cfg.quiet_mode)
                                    begin
                                        steps_next      = steps_inc;
                                        poll_count_next = '0;
                                        n               = 2'd1;
                                        ev0             = EV_LONG;
                                        cnt0            = RES_CNT_W'(steps_inc);
                                    end
                                    polling_next = 1'b1;
                                end
                            end
                            if (cfg.clear_each_poll)
                            begin
                                ind_next = 1'b0;
                            end
                        end
                    end
                end
                OP_CLEAR:
                begin
                    if (clear_value)
                    begin
                        ind_next = 1'b0;
                    end
                end
                OP_RESERVED: ;
            endcase
        end
    end

    always_comb
    begin
        push.count                   = n;
        push.first.event_res         = ev0;
        push.first.long_press_count  = cnt0;
        push.first.indicated         = ind_next;
        push.first.last              = (n == 2'd1);
        push.second.event_res        = ev1;
        push.second.long_press_count = '0;
        push.second.indicated        = ind_next;
        push.second.last             = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polling_reg    <= 1'b0;
            int_en_reg     <= 1'b1;
            ms_count_reg   <= '0;
            poll_count_reg <= '0;
            steps_reg      <= '0;
            ind_reg        <= 1'b0;
        end
        else
        begin
            polling_reg    <= polling_next;
            int_en_reg     <= int_en_next;
            ms_count_reg   <= ms_count_next;
            poll_count_reg <= poll_count_next;
            steps_reg      <= steps_next;
            ind_reg        <= ind_next;
        end
    end

endmodule

// ----- design/bld_out_fifo.sv -----
module bld_out_fifo
    import bld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  push_t                 push,
    input  logic                  pop,
    output logic                  head_valid,
    output result_t               head,
    output logic [FIFO_CNT_W-1:0] count
);

    result_t                entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;
    logic                   do_pop;

    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(do_pop);
        count_next  = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + 1'b1] <= push.second;
        end
    end

endmodule

// ----- design/button_long_press_detector_core.sv -----
// A result reaches m_tvalid through the input register and the result queue.
// One request per cycle while s_tready is high; the step logic updates all its state
// registers together, and a request that yields two results writes both to the queue.
// Input is held off only when the four-entry result queue could overflow.
// Reset (rst_n low, asynchronous) stops polling, enables interrupts, clears all
// counts, the indicated flag and the queue, and loads the register defaults.
module button_long_press_detector_core
    import bld_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // int_status, pin_level, clear_value, zero pad
    input  logic [1:0]            s_tuser,   // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // long_press_count[15:0], indicated, zero pad
    output logic [1:0]            m_tuser,   // event_res
    output logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t                  cfg;
    push_t                 push;
    result_t               head;
    logic                  head_valid;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W:0]   fill_next;

    logic    item_valid_reg;
    opcode_t opcode_reg;
    logic    int_status_reg;
    logic    pin_level_reg;
    logic    clear_value_reg;

    bld_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bld_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid_reg),
        .opcode      (opcode_reg),
        .int_status  (int_status_reg),
        .pin_level   (pin_level_reg),
        .clear_value (clear_value_reg),
        .cfg         (cfg),
        .push        (push)
    );

    bld_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (m_tready),
        .head_valid (head_valid),
        .head       (head),
        .count      (fifo_count)
    );

    // Room for two more results after this cycle's push and pop.
    assign fill_next = (FIFO_CNT_W+1)'(fifo_count) + (FIFO_CNT_W+1)'(push.count)
                     - (FIFO_CNT_W+1)'(m_tready && head_valid);
    assign s_tready  = (fill_next <= (FIFO_CNT_W+1)'(FIFO_DEPTH - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= s_tvalid && s_tready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            opcode_reg      <= opcode_t'(s_tuser);
            int_status_reg  <= s_tdata[0];
            pin_level_reg   <= s_tdata[1];
            clear_value_reg <= s_tdata[2];
        end
    end

    assign m_tvalid = head_valid;
    assign m_tuser  = head.event_res;
    assign m_tdata  = {7'd0, head.indicated, head.long_press_count};
    assign m_tlast  = head.last;

endmodule

// ----- dv/press_event_checker.sv -----
module press_event_checker
    import bld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // int_status, pin_level, clear_value, zero pad
    input  logic [1:0]            s_tuser,   // opcode
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,   // long_press_count[15:0], indicated, zero pad
    input  logic [1:0]            m_tuser,   // event_res
    input  logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output int                    fail_count,
    output int                    events_due,
    output int                    events_checked
);

    localparam int REPORT_MAX = 40;

    cfg_t        cfg;
    logic        polling;
    logic        int_enabled;
    logic        indicated;
    logic [15:0] ms_count;
    logic [15:0] poll_count;
    logic [15:0] press_steps;
    result_t     expected_events[$];

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic result_t make_event(input event_t ev, input logic [15:0] cnt);
        result_t r;
        r.event_res        = ev;
        r.long_press_count = cnt;
        r.indicated        = 1'b0;
        r.last             = 1'b0;
        return r;
    endfunction

    task automatic report_field(input string field, input int unsigned want,
                                input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        end
    endtask

    // Advances the button state by one request and queues the events it causes.
    task automatic predict_press_events(input opcode_t op, input logic int_status,
                                        input logic pin, input logic clr);
        result_t found [2];
        int      n;
        n = 0;
        case (op)
            OP_INTERRUPT:
                if (int_enabled && int_status)
                begin
                    int_enabled = 1'b0;
                    found[n]    = make_event(EV_PRESSED, 16'd0);
                    n++;
                    poll_count  = '0;
                    press_steps = '0;
                    polling     = 1'b1;
                    ms_count    = '0;
                end
            OP_TICK:
                if (polling)
                begin
                    ms_count = sat_inc16(ms_count);
                    if (ms_count >= cfg.poll_period_ms)
                    begin
                        ms_count = '0;
                        polling  = 1'b0;
                        // A poll that finds the flag still set just stops polling.
                        if (!indicated)
                        begin
                            if ((pin ^ cfg.active_low) == 1'b0)
                            begin
                                if (press_steps == 0)
                                begin
                                    if (!cfg.quiet_mode)
                                    begin
                                        found[n]  = make_event(EV_SHORT, 16'd0);
                                        n++;
                                        indicated = 1'b1;
                                    end
                                end
                                else if (!cfg.quiet_mode)
                                    indicated = 1'b1;
                                int_enabled = 1'b1;
                                found[n]    = make_event(EV_RELEASED, 16'd0);
                                n++;
                            end
                            else
                            begin
                                poll_count = sat_inc16(poll_count);
                                if (poll_count == cfg.long_press_polls && !cfg.quiet_mode)
                                begin
                                    press_steps = sat_inc16(press_steps);
                                    found[n]    = make_event(EV_LONG, press_steps);
                                    n++;
                                    poll_count  = '0;
                                end
                                polling  = 1'b1;
                                ms_count = '0;
                            end
                        end
                        if (cfg.clear_each_poll)
                            indicated = 1'b0;
                    end
                end
            OP_CLEAR:
                if (clr)
                    indicated = 1'b0;
            default: ;
        endcase
        for (int k = 0; k < n; k++)
        begin
            found[k].indicated = indicated;
            found[k].last      = (k == n - 1);
            expected_events.push_back(found[k]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            cfg.poll_period_ms   = POLL_PERIOD_RST;
            cfg.long_press_polls = LONG_POLLS_RST;
            cfg.clear_each_poll  = CLEAR_EACH_POLL_RST;
            cfg.active_low       = ACTIVE_LOW_RST;
            cfg.quiet_mode       = QUIET_MODE_RST;
            polling              = 1'b0;
            int_enabled          = 1'b1;
            indicated            = 1'b0;
            ms_count             = '0;
            poll_count           = '0;
            press_steps          = '0;
            expected_events.delete();
            events_due           = 0;
            fail_count           = 0;
            events_checked       = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_POLL_PERIOD:     cfg.poll_period_ms   = pwdata[15:0];
                    REG_LONG_POLLS:      cfg.long_press_polls = pwdata[15:0];
                    REG_CLEAR_EACH_POLL: cfg.clear_each_poll  = pwdata[0];
                    REG_ACTIVE_LOW:      cfg.active_low       = pwdata[0];
                    REG_QUIET_MODE:      cfg.quiet_mode       = pwdata[0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                predict_press_events(opcode_t'(s_tuser), s_tdata[0], s_tdata[1], s_tdata[2]);

            if (m_tvalid && m_tready)
            begin
                events_checked++;
                if (expected_events.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $error("unexpected result: event_res %0d, long_press_count %0d",
                               m_tuser, m_tdata[15:0]);
                end
                else
                begin
                    want = expected_events.pop_front();
                    report_field("event_res", want.event_res, m_tuser);
                    report_field("long_press_count", want.long_press_count, m_tdata[15:0]);
                    report_field("indicated", want.indicated, m_tdata[16]);
                    report_field("last", want.last, m_tlast);
                end
            end
            events_due = expected_events.size();
        end
    end

endmodule

// ----- dv/button_long_press_detector_core_tb.sv -----
module button_long_press_detector_core_tb;
    import bld_pkg::*;

    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_REQUESTS = 1750;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic [1:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int fail_count;
    int events_due;
    int events_checked;

    int cycle_count     = 0;
    int rx_wait         = 0;
    bit idle_on         = 1'b1;
    int requests_sent   = 0;
    int settings_used   = 0;
    int random_base;
    int phase_end;
    int held;

    // Current register values, needed to line ticks up with polls.
    logic [15:0] period_now = POLL_PERIOD_RST;
    logic [15:0] polls_now  = LONG_POLLS_RST;
    logic        auto_now   = CLEAR_EACH_POLL_RST;
    logic        low_now    = ACTIVE_LOW_RST;
    logic        quiet_now  = QUIET_MODE_RST;

    button_long_press_detector_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    press_event_checker u_press_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .fail_count     (fail_count),
        .events_due     (events_due),
        .events_checked (events_checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL button_long_press_detector_core");
            $finish;
        end
    end

    // With idle_on set, the receiver stalls for a fresh random number of cycles after each result.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            rx_wait <= idle_on ? $urandom_range(0, 19) : 0;
        else if (rx_wait != 0)
            rx_wait <= rx_wait - 1;
    end

    always @(negedge clk)
        m_tready <= (rx_wait == 0);

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send(input opcode_t op, input logic int_status, input logic pin,
                        input logic clr);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, clr, pin, int_status};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        requests_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (events_due != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] period, input logic [15:0] polls,
                                  input logic auto_clr, input logic act_low,
                                  input logic quiet);
        settle();
        write_reg(REG_POLL_PERIOD, {16'd0, period});
        write_reg(REG_LONG_POLLS, {16'd0, polls});
        write_reg(REG_CLEAR_EACH_POLL, {31'd0, auto_clr});
        write_reg(REG_ACTIVE_LOW, {31'd0, act_low});
        write_reg(REG_QUIET_MODE, {31'd0, quiet});
        period_now = period;
        polls_now  = polls;
        auto_now   = auto_clr;
        low_now    = act_low;
        quiet_now  = quiet;
        settings_used++;
    endtask

    // One press: interrupt, held polls, then a release poll. Only poll ticks carry a
    // meaningful pin level. With auto-clear and quiet mode off the flag is cleared before
    // the next press, since a poll that finds it set would stall the block for good.
    task automatic press_cycle(input int hold_polls, input bit noisy);
        int tpp;
        tpp = (period_now == 0) ? 1 : period_now;
        if (noisy && $urandom_range(0, 9) == 0)
            send(OP_INTERRUPT, 1'b0, rbit(), rbit());
        send(OP_INTERRUPT, 1'b1, rbit(), rbit());
        for (int p = 0; p <= hold_polls; p++)
        begin
            for (int t = 1; t <= tpp; t++)
            begin
                if (noisy && $urandom_range(0, 7) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       send(OP_CLEAR, rbit(), rbit(), rbit());
                        1:       send(OP_RESERVED, rbit(), rbit(), rbit());
                        default: send(OP_INTERRUPT, rbit(), rbit(), rbit());
                    endcase
                end
                if (t < tpp)
                    send(OP_TICK, rbit(), rbit(), rbit());
                else
                    send(OP_TICK, rbit(), (p < hold_polls) ? ~low_now : low_now, rbit());
            end
        end
        if (!auto_now && !quiet_now)
        begin
            if (rbit())
                send(OP_CLEAR, rbit(), rbit(), 1'b0);
            send(OP_CLEAR, rbit(), rbit(), 1'b1);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: requests that are ignored, then the basic event sequences.
        apply_settings(16'd1, 16'd2, 1'b1, 1'b0, 1'b0);
        send(OP_TICK, 1'b1, 1'b1, 1'b1);
        send(OP_CLEAR, 1'b0, 1'b0, 1'b0);
        send(OP_CLEAR, 1'b1, 1'b1, 1'b1);
        send(OP_RESERVED, 1'b1, 1'b1, 1'b1);
        send(OP_RESERVED, 1'b0, 1'b0, 1'b0);
        send(OP_INTERRUPT, 1'b0, 1'b1, 1'b1);
        send(OP_INTERRUPT, 1'b1, 1'b0, 1'b0);
        send(OP_INTERRUPT, 1'b1, 1'b1, 1'b1);
        repeat (4) send(OP_TICK, 1'b0, 1'b1, 1'b0);
        send(OP_TICK, 1'b1, 1'b0, 1'b1);
        press_cycle(0, 1'b0);

        apply_settings(16'd0, 16'd3, 1'b0, 1'b1, 1'b0);
        press_cycle(4, 1'b0);
        press_cycle(0, 1'b0);

        apply_settings(16'd2, 16'd2, 1'b1, 1'b1, 1'b1);
        press_cycle(5, 1'b0);

        apply_settings(16'd1, 16'd0, 1'b0, 1'b0, 1'b0);
        press_cycle(6, 1'b0);

        // Extremes run back to back: the longest poll period and long-press
        // interval, with ticks and polls well short of them, then a release.
        idle_on = 1'b0;
        apply_settings(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        send(OP_INTERRUPT, 1'b1, 1'b0, 1'b0);
        repeat (20) send(OP_TICK, 1'b0, 1'b1, 1'b0);
        apply_settings(16'd1, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        repeat (20) send(OP_TICK, 1'b0, 1'b1, 1'b0);
        send(OP_TICK, 1'b0, 1'b0, 1'b0);

        random_base = requests_sent;
        while (requests_sent - random_base < RANDOM_REQUESTS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            apply_settings(($urandom_range(0, 3) == 0) ? 16'($urandom_range(3, 5))
                                                       : 16'($urandom_range(0, 2)),
                           16'($urandom_range(0, 5)), rbit(), rbit(),
                           ($urandom_range(0, 2) == 0));
            phase_end = requests_sent + $urandom_range(100, 220);
            while (requests_sent < phase_end)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    // Stray requests while the block is not polling.
                    case ($urandom_range(0, 3))
                        0:       send(OP_TICK, rbit(), rbit(), rbit());
                        1:       send(OP_CLEAR, rbit(), rbit(), rbit());
                        2:       send(OP_RESERVED, rbit(), rbit(), rbit());
                        default: send(OP_INTERRUPT, 1'b0, rbit(), rbit());
                    endcase
                end
                else
                begin
                    if (polls_now == 0)
                        held = $urandom_range(0, 8);
                    else
                        held = $urandom_range(0, 3 * polls_now + 1);
                    press_cycle(held, 1'b1);
                end
            end
        end

        // Last: leave the flag set so that the next poll stops polling for good.
        idle_on = 1'b1;
        apply_settings(16'd1, 16'd2, 1'b0, 1'b0, 1'b0);
        send(OP_INTERRUPT, 1'b1, 1'b0, 1'b0);
        send(OP_TICK, 1'b0, 1'b0, 1'b0);
        send(OP_CLEAR, 1'b1, 1'b1, 1'b0);
        send(OP_INTERRUPT, 1'b1, 1'b1, 1'b1);
        repeat (3) send(OP_TICK, 1'b1, 1'b1, 1'b1);
        send(OP_INTERRUPT, 1'b1, 1'b0, 1'b0);
        send(OP_TICK, 1'b0, 1'b0, 1'b0);
        settle();

        if (events_due != 0)
            $error("%0d expected results never arrived", events_due);
        $display("Run covered %0d requests (%0d random) under %0d register settings; %0d %s",
                 requests_sent, requests_sent - random_base, settings_used, events_checked,
                 "results checked.");
        $display("It included idle and back-to-back traffic, period extremes and a stuck poll.");
        if (fail_count == 0 && events_due == 0)
            $display("PASS button_long_press_detector_core");
        else
            $display("FAIL button_long_press_detector_core");
        $finish;
    end

endmodule
